// File: rtl/bitmap_first_free_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap first-free allocator
// Shared property wrappers; clock and reset are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Types and constants shared by the bitmap first-free allocator modules.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // Map size default and field widths
    localparam int MAP_ENTRIES_DEF = 8192;
    localparam int NUM_W           = 14;
    localparam int STATUS_W        = 2;
    localparam int WORD_BITS       = 64;
    localparam int BIT_SEL_W       = 6;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // Configuration port
    localparam int                APB_ADDR_W        = 3;
    localparam int                APB_DATA_W        = 32;
    localparam logic              REG_BLOCKS_IN_USE = 1'b0;  // register select bit paddr[2]
    localparam logic [NUM_W-1:0]  BLOCKS_RESET      = 14'd8192;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_en;     // write a zero word during the clearing pass
        logic load_req;     // capture an accepted transaction
        logic alloc_start;  // read word 0 and begin the scan
        logic free_start;   // read the word that holds the entry to free
        logic scan_en;      // evaluate the current word, read the next
        logic free_wr;      // write back the word with the bit cleared
        logic set_full;     // result: map full
        logic set_invalid;  // result: invalid entry number
        logic out_load;     // move the result into the output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic req_mode;
        logic req_bad;
        logic cnt_zero;
        logic hit;
        logic exhausted;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer for the allocator: clearing pass, request decode, word scan,
// free read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module bffa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bffa_pkg::dp_stat_t stat,
    output bffa_pkg::ctl_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DECODE  = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_FREE_WR = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.req_mode)
                begin
                    if (stat.cnt_zero)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.alloc_start = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
                else if (stat.req_bad)
                begin
                    cmd.set_invalid = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.free_start = 1'b1;
                    state_next     = S_FREE_WR;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.hit || stat.exhausted)
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bffa_datapath.sv
// ----------------------------------------------------------------------------
// bffa_datapath
// Bitmap word memory, scan pointers, first-free encoder, request and result
// registers, and the output register of the result stream.
// ----------------------------------------------------------------------------
module bffa_datapath
#(
    parameter int MAP_ENTRIES = bffa_pkg::MAP_ENTRIES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bffa_pkg::ctl_cmd_t            cmd,
    output bffa_pkg::dp_stat_t            stat,
    input  logic [bffa_pkg::NUM_W-1:0]    blocks_in_use,
    input  logic                          req_mode,
    input  logic [bffa_pkg::NUM_W-1:0]    req_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bffa_pkg::NUM_W-1:0]    out_number,
    output logic [bffa_pkg::STATUS_W-1:0] out_status
);

    localparam int NUM_W    = bffa_pkg::NUM_W;
    localparam int WB       = bffa_pkg::WORD_BITS;
    localparam int BS_W     = bffa_pkg::BIT_SEL_W;
    localparam int MAP_WORDS = (MAP_ENTRIES + WB - 1) / WB;
    localparam int WORD_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SPAN_W   = (((WORD_W + BS_W) > NUM_W) ? (WORD_W + BS_W) : NUM_W) + 1;

    // Bitmap memory, one word per row
    logic [WB-1:0] mem [MAP_WORDS];
    logic [WB-1:0] rdata_reg;

    // Request and scan registers
    logic                          mode_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [NUM_W-1:0]              cnt_reg;
    logic [WORD_W-1:0]             clr_ptr_reg;
    logic [WORD_W-1:0]             clr_ptr_next;
    logic [WORD_W-1:0]             rd_ptr_reg;
    logic [WORD_W-1:0]             eval_ptr_reg;
    logic [NUM_W-1:0]              res_num_reg;
    logic [bffa_pkg::STATUS_W-1:0] res_status_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [NUM_W-1:0]              out_num_reg;
    logic [bffa_pkg::STATUS_W-1:0] out_status_reg;

    // Combinational signals
    logic [NUM_W-1:0]  cnt_eff;
    logic [WORD_W-1:0] last_word;
    logic [NUM_W-1:0]  free_idx;
    logic [WORD_W-1:0] free_word;
    logic [BS_W-1:0]   free_bit;
    logic [SPAN_W-1:0] span_rem;
    logic [WB-1:0]     range_mask;
    logic [WB-1:0]     free_vec;
    logic [WB-1:0]     first_onehot;
    logic [BS_W-1:0]   first_pos;
    logic              word_has_free;
    logic              hit;
    logic              exhausted;
    logic              rd_en;
    logic [WORD_W-1:0] rd_addr;
    logic              wr_en;
    logic [WORD_W-1:0] wr_addr;
    logic [WB-1:0]     wr_data;

    // Limit the configured count to the map size
    always_comb
    begin
        cnt_eff = blocks_in_use;
        if (32'(blocks_in_use) > MAP_ENTRIES)
        begin
            cnt_eff = NUM_W'(MAP_ENTRIES);
        end
    end

    // Decode the captured request
    assign last_word = WORD_W'((cnt_reg - NUM_W'(1)) >> BS_W);
    assign free_idx  = num_reg - NUM_W'(1);
    assign free_word = WORD_W'(free_idx >> BS_W);
    assign free_bit  = free_idx[BS_W-1:0];

    // Treat bits at or above the count as used
    always_comb
    begin
        span_rem = SPAN_W'(cnt_reg) - SPAN_W'({eval_ptr_reg, {BS_W{1'b0}}});
        if (span_rem >= SPAN_W'(WB))
        begin
            range_mask = '1;
        end
        else
        begin
            range_mask = ~({WB{1'b1}} << span_rem[BS_W-1:0]);
        end
    end

    // Find the lowest free bit of the word under evaluation
    assign free_vec      = ~rdata_reg & range_mask;
    assign first_onehot  = free_vec & (~free_vec + WB'(1));
    assign word_has_free = |free_vec;

    always_comb
    begin
        first_pos = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                first_pos = BS_W'(b);
            end
        end
    end

    assign hit       = cmd.scan_en && word_has_free;
    assign exhausted = cmd.scan_en && !word_has_free && (eval_ptr_reg == last_word);

    // Select the read address
    always_comb
    begin
        rd_en   = cmd.alloc_start || cmd.free_start || cmd.scan_en;
        rd_addr = rd_ptr_reg;
        if (cmd.alloc_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.free_start)
        begin
            rd_addr = free_word;
        end
    end

    // Select the write address and data
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = free_word;
        wr_data = rdata_reg & ~(WB'(1) << free_bit);
        if (cmd.clear_en)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
            wr_data = '0;
        end
        else if (hit)
        begin
            wr_en   = 1'b1;
            wr_addr = eval_ptr_reg;
            wr_data = rdata_reg | first_onehot;
        end
        else if (cmd.free_wr)
        begin
            wr_en = 1'b1;
        end
    end

    // Bitmap memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Capture request, advance scan pointers, record result
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= req_mode;
            num_reg  <= req_number;
            cnt_reg  <= cnt_eff;
        end
        if (rd_en)
        begin
            eval_ptr_reg <= rd_addr;
            if (rd_addr == last_word)
            begin
                rd_ptr_reg <= rd_addr;
            end
            else
            begin
                rd_ptr_reg <= rd_addr + WORD_W'(1);
            end
        end
        if (hit)
        begin
            res_num_reg    <= NUM_W'({eval_ptr_reg, first_pos}) + NUM_W'(1);
            res_status_reg <= bffa_pkg::ST_OK;
        end
        else if (exhausted || cmd.set_full)
        begin
            res_num_reg    <= '0;
            res_status_reg <= bffa_pkg::ST_FULL;
        end
        else if (cmd.set_invalid)
        begin
            res_num_reg    <= '0;
            res_status_reg <= bffa_pkg::ST_INVALID;
        end
        else if (cmd.free_wr)
        begin
            res_num_reg    <= '0;
            res_status_reg <= bffa_pkg::ST_OK;
        end
        if (cmd.out_load)
        begin
            out_num_reg    <= res_num_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Clearing pointer and output valid
    always_comb
    begin
        clr_ptr_next = clr_ptr_reg;
        if (cmd.clear_en && !stat.clear_done)
        begin
            clr_ptr_next = clr_ptr_reg + WORD_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_ptr_reg   <= clr_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.clear_done = (clr_ptr_reg == WORD_W'(MAP_WORDS - 1));
        stat.req_mode   = mode_reg;
        stat.req_bad    = (num_reg == '0) || (num_reg > cnt_reg);
        stat.cnt_zero   = (cnt_reg == '0);
        stat.hit        = hit;
        stat.exhausted  = exhausted;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_number = out_num_reg;
    assign out_status = out_status_reg;

endmodule

// File: rtl/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over a bitmap of used entries, with an APB register
// for the number of entries in use.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Signals                          | Contents
//  ---------+-----------+----------------------------------+----------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser | entry_number, mode
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser | granted_number, status
//  APB      | in/out    | psel penable pwrite paddr ...     | blocks_in_use at 0x0
//
// Allocation scans the 64-bit map words from word 0 up to the one that holds the
// first free bit, at most ceil(count/64) words; the memory read port delivers one
// word per cycle. A free reads one map word and writes it back with the bit
// cleared; a rejected request or an allocation under a zero count sets its status
// without reading the map. After reset a clearing pass writes every map word once
// while s_tready stays low; register writes are taken throughout.
// One request is in flight at a time; a finished result waits in the output
// register, and a further result waits in the block while m_tready is low.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
#(
    parameter int MAP_ENTRIES = bffa_pkg::MAP_ENTRIES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bffa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bffa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bffa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [13:0] entry_number, [15:14] zero
    input  logic                              s_tuser,   // [0] mode
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [13:0] granted_number, [15:14] zero
    output logic [bffa_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);

    logic [bffa_pkg::NUM_W-1:0] blocks_in_use_reg;
    logic [bffa_pkg::NUM_W-1:0] blocks_in_use_next;
    logic                       cfg_wr;
    logic [bffa_pkg::NUM_W-1:0] out_number;
    bffa_pkg::ctl_cmd_t         cmd;
    bffa_pkg::dp_stat_t         stat;

    // Register write decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == bffa_pkg::REG_BLOCKS_IN_USE);

    always_comb
    begin
        blocks_in_use_next = blocks_in_use_reg;
        if (cfg_wr)
        begin
            blocks_in_use_next = pwdata[bffa_pkg::NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= bffa_pkg::BLOCKS_RESET;
        end
        else
        begin
            blocks_in_use_reg <= blocks_in_use_next;
        end
    end

    // Register read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bffa_pkg::REG_BLOCKS_IN_USE)
        begin
            prdata = bffa_pkg::APB_DATA_W'(blocks_in_use_reg);
        end
    end

    bffa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bffa_datapath
    #(
        .MAP_ENTRIES (MAP_ENTRIES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .blocks_in_use (blocks_in_use_reg),
        .req_mode      (s_tuser),
        .req_number    (s_tdata[bffa_pkg::NUM_W-1:0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_number    (out_number),
        .out_status    (m_tuser)
    );

    assign m_tdata = 16'(out_number);

endmodule

// File: rtl/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_macros.svh"

module bffa_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [15:0]                   m_tdata,
    input logic [bffa_pkg::STATUS_W-1:0] m_tuser
);

    logic result_failed;
    logic status_known;
    logic out_stalled;

    // Qualify the result stream
    assign result_failed = m_tvalid && (m_tuser != bffa_pkg::ST_OK);
    assign status_known  = (m_tuser == bffa_pkg::ST_OK) || (m_tuser == bffa_pkg::ST_FULL) ||
                           (m_tuser == bffa_pkg::ST_INVALID);
    assign out_stalled   = m_tvalid && !m_tready;

    // One request at a time: input closes right after a transaction
    `BFFA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "accepted while busy")

    // Failed requests never grant an entry
    `BFFA_ASSERT_SAME(a_fail_no_grant, result_failed, m_tdata == 16'd0, "grant on failure")

    // Status is always a defined code
    `BFFA_ASSERT_SAME(a_status_code, m_tvalid, status_known, "undefined status")

    // A stalled result holds
    `BFFA_ASSERT_NEXT(a_out_hold, out_stalled, m_tvalid && $stable({m_tdata, m_tuser}), "result changed")

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - bitmap first-free allocator testbench
// Drives allocate and free requests over the request stream, sets the entry
// count over APB between phases, and compares every result with a bench bitmap
// predictor or a typed row's value. A short directed table comes first, then
// random phases with random counts, sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_W         = bffa_pkg::NUM_W;
    localparam int STATUS_W      = bffa_pkg::STATUS_W;
    localparam int APB_ADDR_W    = bffa_pkg::APB_ADDR_W;
    localparam int APB_DATA_W    = bffa_pkg::APB_DATA_W;
    localparam int MAP_SIZE      = bffa_pkg::MAP_ENTRIES_DEF;
    localparam int NUMBER_MAX    = (1 << NUM_W) - 1;
    localparam int RANDOM_ITEMS  = 530;
    localparam int IDLE_LIMIT    = 4000;
    // one full scan of the map plus some margin
    localparam int SETTLE_CYCLES = MAP_SIZE / bffa_pkg::WORD_BITS + 16;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [APB_ADDR_W-1:0] ADDR_BLOCKS_IN_USE = {bffa_pkg::REG_BLOCKS_IN_USE, 2'b00};

    typedef struct packed {
        logic [NUM_W-1:0]    granted;
        logic [STATUS_W-1:0] status;
    } alloc_result_t;

    typedef struct {
        logic          is_count;   // row rewrites blocks_in_use instead of a request
        logic          mode;
        logic [NUM_W-1:0] number;  // entry number, or the new count
        logic          typed;      // expected result is given in the row
        alloc_result_t want;
    } stim_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_THROTTLE, RX_CHOKE} rx_style_t;

    // Clock, reset and DUT ports
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;   // [13:0] entry_number, [15:14] zero
    logic                  s_tuser  = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [13:0] granted_number, [15:14] zero
    logic [STATUS_W-1:0]   m_tuser;         // [1:0] status

    // Predictor state
    bit               used_map [MAP_SIZE];
    logic [NUM_W-1:0] block_count_model = bffa_pkg::BLOCKS_RESET;
    int               highest_granted   = 0;

    // Expected results and bench bookkeeping
    alloc_result_t    expected_results [$];
    stim_row_t        directed_rows [$];
    logic             row_typed  = 1'b0;
    alloc_result_t    row_expect = '0;
    int               error_count = 0;
    int               idle_cycles = 0;
    int               burst_left  = 0;
    rx_style_t        rx_style    = RX_OPEN;
    int               rx_span     = 0;
    int               rx_tick     = 0;

    bitmap_first_free_allocator #(
        .MAP_ENTRIES (MAP_SIZE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Generate the clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_failure(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Clamp the programmed count to the map size
    function automatic int effective_count();
        return (int'(block_count_model) > MAP_SIZE) ? MAP_SIZE : int'(block_count_model);
    endfunction

    // Apply one request to the bitmap and return its result
    function automatic alloc_result_t predict_result(input logic mode,
                                                     input logic [NUM_W-1:0] number);
        alloc_result_t res;
        int            count;
        int            idx;
        bit            found;
        count      = effective_count();
        res.granted = '0;
        res.status  = bffa_pkg::ST_OK;
        found       = 1'b0;
        if (mode == MODE_ALLOC)
        begin
            for (idx = 0; idx < count && !found; idx++)
            begin
                if (!used_map[idx])
                begin
                    used_map[idx] = 1'b1;
                    res.granted   = NUM_W'(idx + 1);
                    found         = 1'b1;
                    if (idx + 1 > highest_granted)
                        highest_granted = idx + 1;
                end
            end
            if (!found)
                res.status = bffa_pkg::ST_FULL;
        end
        else if (number == '0 || int'(number) > count)
            res.status = bffa_pkg::ST_INVALID;
        else
            used_map[int'(number) - 1] = 1'b0;
        return res;
    endfunction

    function automatic void plan_request(input logic mode, input logic [NUM_W-1:0] number,
                                         input logic typed, input int granted,
                                         input logic [STATUS_W-1:0] status);
        stim_row_t row;
        row.is_count     = 1'b0;
        row.mode         = mode;
        row.number       = number;
        row.typed        = typed;
        row.want.granted = NUM_W'(granted);
        row.want.status  = status;
        directed_rows.push_back(row);
    endfunction

    function automatic void plan_count(input logic [NUM_W-1:0] value);
        stim_row_t row;
        row.is_count = 1'b1;
        row.mode     = MODE_ALLOC;
        row.number   = value;
        row.typed    = 1'b0;
        row.want     = '0;
        directed_rows.push_back(row);
    endfunction

    // Present one request in bursts with random gaps; return once accepted
    task automatic issue_request(input logic mode, input logic [NUM_W-1:0] number,
                                 input logic typed, input alloc_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(15, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid   = 1'b1;
        s_tdata    = {{(16 - NUM_W){1'b0}}, number};
        s_tuser    = mode;
        row_typed  = typed;
        row_expect = want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold the sender until every pending result has come out
    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write blocks_in_use; upper data bits carry random junk
    task automatic write_block_count(input logic [NUM_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_BLOCKS_IN_USE;
        pwdata  = ($urandom << NUM_W) | APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        block_count_model = value;
        @(negedge clk);
        // Read the register back
        if (prdata !== APB_DATA_W'(value))
            report_failure($sformatf("blocks_in_use reads %0d, expected %0d", prdata, value));
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Predict each accepted request
    always @(posedge clk)
    begin : capture_request
        alloc_result_t predicted;
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted = predict_result(s_tuser, s_tdata[NUM_W-1:0]);
            if (row_typed)
                predicted = row_expect;
            expected_results.push_back(predicted);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_result
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_failure($sformatf("result granted %0d status %0d with nothing pending",
                                         m_tdata[NUM_W-1:0], m_tuser));
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[NUM_W-1:0] !== want.granted)
                    report_failure($sformatf("granted_number %0d, expected %0d",
                                             m_tdata[NUM_W-1:0], want.granted));
                if (m_tuser !== want.status)
                    report_failure($sformatf("status %0d, expected %0d",
                                             m_tuser, want.status));
                if (m_tdata[15:NUM_W] !== '0)
                    report_failure($sformatf("tdata pad bits %0b, expected zero",
                                             m_tdata[15:NUM_W]));
            end
        end
    end

    // Stall the result stream on its own rotating pattern
    always @(negedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_span  = $urandom_range(16, 150);
        end
        rx_span--;
        rx_tick++;
        case (rx_style)
            RX_OPEN:     m_tready = 1'b1;
            RX_RANDOM:   m_tready = ($urandom_range(0, 9) < 7);
            RX_THROTTLE: m_tready = (rx_tick % 4 != 0);
            default:     m_tready = (rx_tick % 16 < 3);
        endcase
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t        row;
        alloc_result_t    none;
        int               phase_len;
        int               sel;
        int               upper;
        int               random_items;
        logic [NUM_W-1:0] count_value;
        logic [NUM_W-1:0] number;

        none         = '0;
        random_items = 0;

        // Directed table: count starts at its reset value
        plan_request(MODE_ALLOC, NUM_W'(NUMBER_MAX), 1'b1, 1, bffa_pkg::ST_OK);
        plan_request(MODE_ALLOC, 14'd0,      1'b1, 2, bffa_pkg::ST_OK);
        plan_request(MODE_FREE,  14'd0,      1'b1, 0, bffa_pkg::ST_INVALID);
        plan_request(MODE_FREE,  NUM_W'(NUMBER_MAX), 1'b1, 0, bffa_pkg::ST_INVALID);
        plan_request(MODE_FREE,  14'd8193,   1'b1, 0, bffa_pkg::ST_INVALID);
        plan_request(MODE_FREE,  14'd8192,   1'b1, 0, bffa_pkg::ST_OK);      // already free
        plan_request(MODE_FREE,  14'd1,      1'b0, 0, bffa_pkg::ST_OK);
        plan_request(MODE_ALLOC, 14'h1555,   1'b0, 0, bffa_pkg::ST_OK);
        plan_request(MODE_ALLOC, 14'h2AAA,   1'b0, 0, bffa_pkg::ST_OK);
        // small count: map full, free above the count
        plan_count(14'd3);
        plan_request(MODE_ALLOC, 14'd0,      1'b1, 0, bffa_pkg::ST_FULL);
        plan_request(MODE_FREE,  14'd4,      1'b1, 0, bffa_pkg::ST_INVALID);
        plan_request(MODE_FREE,  14'd2,      1'b0, 0, bffa_pkg::ST_OK);
        // lowered count: entry 3 stays marked but out of reach
        plan_count(14'd1);
        plan_request(MODE_ALLOC, 14'd0,      1'b1, 0, bffa_pkg::ST_FULL);
        plan_request(MODE_FREE,  14'd3,      1'b1, 0, bffa_pkg::ST_INVALID);
        // zero count
        plan_count(14'd0);
        plan_request(MODE_ALLOC, 14'd0,      1'b1, 0, bffa_pkg::ST_FULL);
        plan_request(MODE_FREE,  14'd1,      1'b1, 0, bffa_pkg::ST_INVALID);
        // count beyond the map
        plan_count(NUM_W'(NUMBER_MAX));
        plan_request(MODE_ALLOC, 14'd0,      1'b0, 0, bffa_pkg::ST_OK);
        plan_request(MODE_ALLOC, NUM_W'(NUMBER_MAX), 1'b0, 0, bffa_pkg::ST_OK);
        plan_request(MODE_FREE,  14'd8192,   1'b0, 0, bffa_pkg::ST_OK);
        plan_request(MODE_FREE,  14'h1555,   1'b0, 0, bffa_pkg::ST_OK);
        plan_request(MODE_FREE,  14'h2AAA,   1'b1, 0, bffa_pkg::ST_INVALID);
        plan_count(14'd8192);
        plan_request(MODE_ALLOC, 14'd0,      1'b0, 0, bffa_pkg::ST_OK);

        // Hold reset, release on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.is_count)
            begin
                wait_for_results();
                write_block_count(row.number);
            end
            else
                issue_request(row.mode, row.number, row.typed, row.want);
        end

        // Random phases, each under a fresh count
        while (random_items < RANDOM_ITEMS)
        begin
            wait_for_results();
            case ($urandom_range(0, 19))
                0:       count_value = '0;
                1:       count_value = NUM_W'(MAP_SIZE);
                2:       count_value = NUM_W'($urandom_range(MAP_SIZE + 1, NUMBER_MAX));
                3:       count_value = NUM_W'($urandom_range(300, 1500));
                4:       count_value = NUM_W'(1);
                default: count_value = NUM_W'($urandom_range(2, 96));
            endcase
            write_block_count(count_value);
            phase_len = $urandom_range(20, 60);
            if (phase_len > RANDOM_ITEMS - random_items)
                phase_len = RANDOM_ITEMS - random_items;
            repeat (phase_len)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_for_results();
                upper = (effective_count() < highest_granted) ? effective_count()
                                                             : highest_granted;
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    issue_request(MODE_ALLOC, NUM_W'($urandom), 1'b0, none);
                else if (sel < 88 && upper > 0)
                    issue_request(MODE_FREE, NUM_W'($urandom_range(1, upper)), 1'b0, none);
                else
                begin
                    // out-of-range and arbitrary entry numbers
                    case ($urandom_range(0, 3))
                        0:       number = '0;
                        1:       number = NUM_W'(effective_count() + 1);
                        2:       number = NUM_W'($urandom);
                        default: number = NUM_W'(NUMBER_MAX);
                    endcase
                    issue_request(MODE_FREE, number, 1'b0, none);
                end
                random_items++;
            end
        end

        // Drain, then let any stray result show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
